[hw/rtl/assert_macros.svh]
// Assertion macros for the block checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked check, held off while in reset
`define VMY_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// clocked check, active through reset
`define VMY_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[hw/rtl/vmy_pkg.sv]
package vmy_pkg;
	localparam int unsigned MUL_OPS    = 7;
	localparam int unsigned DIV3_STEPS = 4;
	localparam int unsigned ROOT_STEPS = 32;
	localparam int unsigned GRAD_STEPS = 52;
	localparam int unsigned LANES      = 6;
	localparam logic [31:0] INV_SQRT3_Q32 = 32'd2479700525;
	localparam logic [17:0] DIV3_RECIP    = 18'd174763;

	localparam logic [1:0] CFG_YIELD_SHEAR = 2'd0;
	localparam logic [1:0] CFG_KIN_ENABLE  = 2'd1;
	localparam logic [1:0] CFG_ISO_ENABLE  = 2'd2;

	typedef struct packed {
		logic       load;
		logic       capture;
		logic       mul_go;
		logic [2:0] mul_idx;
		logic       div_start;
		logic       div_grad;
		logic [2:0] lane;
		logic       div_step;
		logic       div3_step;
		logic       div_write;
		logic [2:0] wr_lane;
		logic       root_init;
		logic       root_step;
		logic       yield_write;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic f_zero;
	} sts_t;
endpackage

[hw/rtl/vmy_ctrl.sv]
module vmy_ctrl
	import vmy_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic mode,
	output logic in_stall,
	input  logic out_stall,
	output logic out_valid,
	input  sts_t sts,
	output cmd_t cmd
);
	typedef enum logic [6:0] {
		C_IDLE = 7'b0000001,
		C_MUL  = 7'b0000010,
		C_DIV3 = 7'b0000100,
		C_ROOT = 7'b0001000,
		C_FIN  = 7'b0010000,
		C_GRAD = 7'b0100000,
		C_OUT  = 7'b1000000
	} cstate_t;

	cstate_t    state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic [2:0] lane_q, lane_d;
	logic       out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		cnt_d    = cnt_q;
		lane_d   = lane_q;
		in_stall = 1'b1;
		unique case (state_q)
			C_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (mode) begin
						cmd.capture = 1'b1;
						cnt_d       = '0;
						state_d     = C_MUL;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			C_MUL: begin
				cnt_d = cnt_q + 6'd1;
				if (cnt_q < 6'(MUL_OPS)) begin
					cmd.mul_go  = 1'b1;
					cmd.mul_idx = cnt_q[2:0];
				end else begin
					cmd.div_start = 1'b1;
					cnt_d         = '0;
					state_d       = C_DIV3;
				end
			end
			C_DIV3: begin
				cmd.div3_step = 1'b1;
				cnt_d         = cnt_q + 6'd1;
				if (cnt_q == 6'(DIV3_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = C_ROOT;
				end
			end
			C_ROOT: begin
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == '0) begin
					cmd.root_init = 1'b1;
				end else begin
					cmd.root_step = 1'b1;
				end
				if (cnt_q == 6'(ROOT_STEPS)) begin
					cnt_d   = '0;
					state_d = C_FIN;
				end
			end
			C_FIN: begin
				cmd.yield_write = 1'b1;
				if (sts.f_zero) begin
					state_d = C_OUT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_grad  = 1'b1;
					cmd.lane      = '0;
					lane_d        = '0;
					cnt_d         = 6'd1;
					state_d       = C_GRAD;
				end
			end
			C_GRAD: begin
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'(GRAD_STEPS + 1)) begin
					cmd.div_write = 1'b1;
					cmd.wr_lane   = lane_q;
					if (lane_q == 3'(LANES - 1)) begin
						state_d = C_OUT;
					end else begin
						cmd.div_start = 1'b1;
						cmd.div_grad  = 1'b1;
						cmd.lane      = lane_q + 3'd1;
						lane_d        = lane_q + 3'd1;
						cnt_d         = 6'd1;
					end
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			C_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = C_IDLE;
				end
			end
			default: state_d = C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_IDLE;
			cnt_q       <= '0;
			lane_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			lane_q  <= lane_d;
			priority if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

[hw/rtl/vmy_datapath.sv]
module vmy_datapath
	import vmy_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic signed [31:0] comp_xx,
	input  logic signed [31:0] comp_yy,
	input  logic signed [31:0] comp_zz,
	input  logic signed [31:0] comp_yz,
	input  logic signed [31:0] comp_xz,
	input  logic signed [31:0] comp_xy,
	input  logic signed [31:0] iso_hardening,
	output logic signed [31:0] yield_value,
	output logic signed [31:0] grad_xx,
	output logic signed [31:0] grad_yy,
	output logic signed [31:0] grad_zz,
	output logic signed [31:0] grad_yz,
	output logic signed [31:0] grad_xz,
	output logic signed [31:0] grad_xy,
	output logic               grad_zero
);
	logic [30:0]        yield_shear_q;
	logic               kin_en_q, iso_en_q;
	logic signed [31:0] back_q [LANES];
	logic signed [31:0] iso_q;
	logic signed [31:0] h_q [LANES];
	logic signed [31:0] comp [LANES];
	logic signed [31:0] h_new [LANES];
	logic signed [32:0] hsum;

	logic [31:0]        op_a, op_b;
	logic signed [32:0] dif;
	logic signed [31:0] hsel;
	logic [63:0]        prod_q;
	logic [2:0]         pidx_q;
	logic               pvld_q;
	logic [65:0]        dsum_q;
	logic [63:0]        ssum_q;
	logic signed [32:0] iso_term_q;
	logic [31:0]        iso_r;

	logic [63:0] d3_src_q, d3_quo_q;
	logic [1:0]  d3_rem_q;
	logic [17:0] d3_cur, d3_back;
	logic [34:0] d3_prod;
	logic [15:0] d3_qd;

	logic [63:0] num_q, quo_q;
	logic [35:0] rem_q, den_q;
	logic [36:0] rem_sh;
	logic        neg_q;
	logic [51:0] gnum;
	logic [35:0] gden;
	logic        gneg;
	logic signed [34:0] tnorm;
	logic [33:0] mag;
	logic [34:0] f6;

	logic [64:0] j2_sum;
	logic [63:0] j2;
	logic [63:0] rad_q;
	logic [33:0] rrem_q;
	logic [31:0] root_q;
	logic [35:0] rrem_sh, trial;

	logic signed [34:0] yv;
	logic signed [31:0] yield_q;
	logic               gz_q;
	logic signed [31:0] grad_q [LANES];
	logic signed [31:0] gres;

	assign comp[0] = comp_xx;
	assign comp[1] = comp_yy;
	assign comp[2] = comp_zz;
	assign comp[3] = comp_yz;
	assign comp[4] = comp_xz;
	assign comp[5] = comp_xy;

	always_comb begin
		hsum = '0;
		for (int i = 0; i < LANES; i++) begin
			hsum = 33'(comp[i]) + 33'(back_q[i]);
			if (!kin_en_q) begin
				h_new[i] = comp[i];
			end else if (hsum > 33'sd2147483647) begin
				h_new[i] = 32'sh7fffffff;
			end else if (hsum < -33'sd2147483648) begin
				h_new[i] = 32'sh80000000;
			end else begin
				h_new[i] = hsum[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yield_shear_q <= '0;
			kin_en_q      <= 1'b0;
			iso_en_q      <= 1'b0;
			iso_q         <= '0;
			for (int i = 0; i < LANES; i++) begin
				back_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_YIELD_SHEAR: yield_shear_q <= cfg_data[30:0];
					CFG_KIN_ENABLE:  kin_en_q      <= cfg_data[0];
					CFG_ISO_ENABLE:  iso_en_q      <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				for (int i = 0; i < LANES; i++) begin
					back_q[i] <= comp[i];
				end
				iso_q <= iso_hardening;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int i = 0; i < LANES; i++) begin
				h_q[i] <= h_new[i];
			end
		end
	end

	always_comb begin
		dif  = '0;
		hsel = '0;
		op_a = '0;
		op_b = '0;
		unique case (cmd.mul_idx)
			3'd0: dif = 33'(h_q[0]) - 33'(h_q[1]);
			3'd1: dif = 33'(h_q[1]) - 33'(h_q[2]);
			3'd2: dif = 33'(h_q[2]) - 33'(h_q[0]);
			3'd3: hsel = h_q[3];
			3'd4: hsel = h_q[4];
			3'd5: hsel = h_q[5];
			3'd6: hsel = iso_q;
			default: ;
		endcase
		if (cmd.mul_idx < 3'd3) begin
			op_a = dif[32] ? 32'(-dif) : dif[31:0];
			op_b = op_a;
		end else if (cmd.mul_idx < 3'd6) begin
			op_a = hsel[31] ? 32'(-33'(hsel)) : hsel;
			op_b = op_a;
		end else begin
			op_a = hsel[31] ? 32'(-33'(hsel)) : hsel;
			op_b = INV_SQRT3_Q32;
		end
	end

	assign iso_r = 32'((65'(prod_q) + 65'h80000000) >> 32);

	always_ff @(posedge clk) begin
		prod_q <= 64'(op_a) * 64'(op_b);
		pidx_q <= cmd.mul_idx;
		if (cmd.capture) begin
			dsum_q     <= '0;
			ssum_q     <= '0;
			iso_term_q <= '0;
			pvld_q     <= 1'b0;
		end else begin
			pvld_q <= cmd.mul_go;
			if (pvld_q) begin
				if (pidx_q < 3'd3) begin
					dsum_q <= dsum_q + 66'(prod_q);
				end else if (pidx_q < 3'd6) begin
					ssum_q <= ssum_q + prod_q;
				end else if (iso_en_q) begin
					iso_term_q <= iso_q[31] ? -33'(iso_r) : 33'(iso_r);
				end
			end
		end
	end

	assign d3_cur  = {d3_rem_q, d3_src_q[63:48]};
	assign d3_prod = 35'(d3_cur) * 35'(DIV3_RECIP);
	assign d3_qd   = d3_prod[34:19];
	assign d3_back = 18'({d3_qd, 1'b0}) + 18'(d3_qd);

	always_ff @(posedge clk) begin
		if (cmd.div_start && !cmd.div_grad) begin
			d3_src_q <= dsum_q[64:1];
			d3_quo_q <= '0;
			d3_rem_q <= '0;
		end else if (cmd.div3_step) begin
			d3_src_q <= {d3_src_q[47:0], 16'b0};
			d3_quo_q <= {d3_quo_q[47:0], d3_qd};
			d3_rem_q <= 2'(d3_cur - d3_back);
		end
	end

	assign f6 = 35'({root_q, 2'b0}) + 35'({root_q, 1'b0});

	always_comb begin
		tnorm = '0;
		unique case (cmd.lane)
			3'd0: tnorm = 35'(h_q[0]) * 35'sd2 - 35'(h_q[1]) - 35'(h_q[2]);
			3'd1: tnorm = 35'(h_q[1]) * 35'sd2 - 35'(h_q[2]) - 35'(h_q[0]);
			3'd2: tnorm = 35'(h_q[2]) * 35'sd2 - 35'(h_q[0]) - 35'(h_q[1]);
			3'd3: tnorm = 35'(h_q[3]);
			3'd4: tnorm = 35'(h_q[4]);
			3'd5: tnorm = 35'(h_q[5]);
			default: ;
		endcase
		gneg = tnorm[34];
		mag  = tnorm[34] ? 34'(-tnorm) : tnorm[33:0];
		if (cmd.lane < 3'd3) begin
			gnum = {1'b0, mag, 17'b0} + 52'(f6);
			gden = {f6, 1'b0};
		end else begin
			gnum = {1'b0, mag, 17'b0} + 52'(root_q);
			gden = 36'({root_q, 1'b0});
		end
	end

	assign rem_sh = {rem_q, num_q[63]};

	always_ff @(posedge clk) begin
		if (cmd.div_start && cmd.div_grad) begin
			num_q <= {gnum, 12'b0};
			den_q <= gden;
			neg_q <= gneg;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[62:0], 1'b0};
			if (rem_sh >= 37'(den_q)) begin
				rem_q <= 36'(rem_sh - 37'(den_q));
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh[35:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign j2_sum  = 65'(d3_quo_q) + 65'(ssum_q);
	assign j2      = j2_sum[64] ? '1 : j2_sum[63:0];
	assign rrem_sh = {rrem_q, rad_q[63:62]};
	assign trial   = 36'({root_q, 2'b01});

	always_ff @(posedge clk) begin
		if (cmd.root_init) begin
			rad_q  <= j2;
			rrem_q <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			rad_q <= {rad_q[61:0], 2'b0};
			if (rrem_sh >= trial) begin
				rrem_q <= 34'(rrem_sh - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rrem_q <= rrem_sh[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign sts.f_zero = (root_q == '0);

	assign yv = 35'({1'b0, root_q}) + 35'(iso_term_q) - 35'({1'b0, yield_shear_q});

	always_comb begin
		if (neg_q) begin
			gres = (quo_q >= 64'h80000000) ? 32'sh80000000 : 32'(-65'(quo_q));
		end else begin
			gres = (quo_q >= 64'h7fffffff) ? 32'sh7fffffff : quo_q[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.yield_write) begin
			if (yv > 35'sd2147483647) begin
				yield_q <= 32'sh7fffffff;
			end else if (yv < -35'sd2147483648) begin
				yield_q <= 32'sh80000000;
			end else begin
				yield_q <= yv[31:0];
			end
			gz_q <= sts.f_zero;
		end
		if (cmd.div_write) begin
			grad_q[cmd.wr_lane] <= gres;
		end
		if (cmd.out_load) begin
			yield_value <= yield_q;
			grad_zero   <= gz_q;
			grad_xx     <= gz_q ? '0 : grad_q[0];
			grad_yy     <= gz_q ? '0 : grad_q[1];
			grad_zz     <= gz_q ? '0 : grad_q[2];
			grad_yz     <= gz_q ? '0 : grad_q[3];
			grad_xz     <= gz_q ? '0 : grad_q[4];
			grad_xy     <= gz_q ? '0 : grad_q[5];
		end
	end
endmodule

[hw/rtl/von_mises_yield_and_normal.sv]
// J2 (von Mises) yield function and gradient, signed Q15.16. A load transaction (mode 0)
// stores the back stress and hardening variable. An evaluate transaction (mode 1) runs
// in turn on the shared 32x32 multiplier, the divide by three (16 bits a cycle by
// reciprocal multiplication), the bit-pair square root, a step that forms the yield value,
// the restoring divider that forms the six gradient quotients (skipped when f is zero),
// and the load of the output register. Input is held off while a transaction is in work,
// and a stalled result holds the next evaluate in its last cycle.
module von_mises_yield_and_normal
	import vmy_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic signed [31:0] comp_xx,
	input  logic signed [31:0] comp_yy,
	input  logic signed [31:0] comp_zz,
	input  logic signed [31:0] comp_yz,
	input  logic signed [31:0] comp_xz,
	input  logic signed [31:0] comp_xy,
	input  logic signed [31:0] iso_hardening,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] yield_value,
	output logic signed [31:0] grad_xx,
	output logic signed [31:0] grad_yy,
	output logic signed [31:0] grad_zz,
	output logic signed [31:0] grad_yz,
	output logic signed [31:0] grad_xz,
	output logic signed [31:0] grad_xy,
	output logic               grad_zero,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	vmy_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (mode),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	vmy_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.comp_xx       (comp_xx),
		.comp_yy       (comp_yy),
		.comp_zz       (comp_zz),
		.comp_yz       (comp_yz),
		.comp_xz       (comp_xz),
		.comp_xy       (comp_xy),
		.iso_hardening (iso_hardening),
		.yield_value   (yield_value),
		.grad_xx       (grad_xx),
		.grad_yy       (grad_yy),
		.grad_zz       (grad_zz),
		.grad_yz       (grad_yz),
		.grad_xz       (grad_xz),
		.grad_xy       (grad_xy),
		.grad_zero     (grad_zero)
	);
endmodule

[hw/rtl/vmy_checker.sv]
`include "assert_macros.svh"

module vmy_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        mode,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] yield_value,
	input logic [31:0] grad_xx,
	input logic [31:0] grad_yy,
	input logic [31:0] grad_zz,
	input logic [31:0] grad_yz,
	input logic [31:0] grad_xz,
	input logic [31:0] grad_xy,
	input logic        grad_zero
);
	logic grads_clear;

	assign grads_clear = grad_xx == 0 && grad_yy == 0 && grad_zz == 0 && grad_yz == 0
		&& grad_xz == 0 && grad_xy == 0;

	`VMY_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
	`VMY_ASSERT(a_busy_after_eval, in_valid && !in_stall && mode |=> in_stall, "eval not held")
	`VMY_ASSERT(a_zero_grad, out_valid && grad_zero |-> grads_clear, "gradient not cleared")
	`VMY_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(yield_value) && $stable(grad_zero), "stalled result changed")
endmodule

bind von_mises_yield_and_normal vmy_checker u_vmy_checker (.*);
